>>> sv/fasta_index_builder_defines.svh
// Assertion macros used by the top-level design file.
`ifndef FASTA_INDEX_BUILDER_DEFINES_SVH
`define FASTA_INDEX_BUILDER_DEFINES_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define FIB_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fasta_index_builder: assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define FIB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fasta_index_builder: assertion failed");
`else
`define FIB_ASSERT_SAME(label, clk, rst, ante, cons)
`define FIB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> sv/fib_pkg.sv
package fib_pkg;

  // Characters that decide the class of a line.
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_AT   = 8'h40;
  localparam logic [7:0] CH_NL   = 8'h0A;

  // Line classes.
  localparam logic [1:0] CLS_SEQ  = 2'd0;
  localparam logic [1:0] CLS_SKIP = 2'd1;
  localparam logic [1:0] CLS_HDR  = 2'd2;
  localparam logic [1:0] CLS_QUAL = 2'd3;

  // Result kinds.
  localparam logic [1:0] KIND_RECORD   = 2'd0;
  localparam logic [1:0] KIND_EMPTY    = 2'd1;
  localparam logic [1:0] KIND_MISMATCH = 2'd2;

  // Width of every offset and count field in a result.
  localparam int OUT_W = 40;

  // Decoupling queue; the depth must be a power of two.
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCOUNT_W = QPTR_W + 1;

  // One classified input byte.
  typedef struct packed {
    logic eoi;
    logic is_nl;
    logic is_comment;
    logic is_plus;
    logic is_header;
  } byte_class_t;

  // Queue status as seen by the front and back ends.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // One index result.
  typedef struct packed {
    logic [1:0]       kind;
    logic [31:0]      record_number;
    logic [OUT_W-1:0] header_offset;
    logic [OUT_W-1:0] sequence_offset;
    logic             has_sequence;
    logic [OUT_W-1:0] sequence_length;
    logic [OUT_W-1:0] line_bases;
    logic [OUT_W-1:0] line_width;
  } result_t;

endpackage

>>> sv/fib_front.sv
module fib_front (
  input  logic [7:0]          data_byte,
  input  logic                end_of_input,
  output fib_pkg::byte_class_t cls
);
  import fib_pkg::*;

  // Decode the byte into the few facts the back end needs.
  always_comb begin
    cls.eoi        = end_of_input;
    cls.is_nl      = (data_byte == CH_NL);
    cls.is_comment = (data_byte == CH_SEMI);
    cls.is_plus    = (data_byte == CH_PLUS);
    cls.is_header  = (data_byte == CH_GT) || (data_byte == CH_AT);
  end

endmodule

>>> sv/fib_queue.sv
module fib_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  fib_pkg::byte_class_t din,
  input  logic                 pop,
  output fib_pkg::byte_class_t dout,
  output fib_pkg::q_status_t   stat
);
  import fib_pkg::*;

  byte_class_t         slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCOUNT_W-1:0] count;

  assign stat.full  = (count == QCOUNT_W'(QDEPTH));
  assign stat.empty = (count == '0);
  assign dout       = slots[rd_ptr];

  // Pointers and fill count; the pointers wrap as the depth is a power of two.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop)      count <= count + QCOUNT_W'(1);
      else if (pop && !push) count <= count - QCOUNT_W'(1);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= din;
  end

endmodule

>>> sv/fib_back.sv
module fib_back #(
  parameter int OFFSET_BITS = 40
) (
  input  logic                 clk,
  input  logic                 rst,
  input  fib_pkg::byte_class_t in_cls,
  input  fib_pkg::q_status_t   q_stat,
  output logic                 pop,
  output logic                 res_valid,
  input  logic                 res_ready,
  output fib_pkg::result_t     res
);
  import fib_pkg::*;

  localparam int OB = OFFSET_BITS;
  localparam logic [OB-1:0] MAXV = {OB{1'b1}};

  function automatic logic [OB-1:0] sat_add(input logic [OB-1:0] a, input logic [OB-1:0] b);
    logic [OB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[OB] ? MAXV : s[OB-1:0];
  endfunction

  function automatic logic [OB-1:0] sat_inc(input logic [OB-1:0] a);
    return (a == MAXV) ? a : a + OB'(1);
  endfunction

  // Parser and record state.
  logic [OB-1:0] byte_position;
  logic          at_line_start;
  logic [1:0]    line_class;
  logic [OB-1:0] cur_count;
  logic [OB-1:0] cur_start;
  logic          qskip;
  logic          header_seen;
  logic [OB-1:0] hdr_start;
  logic [OB-1:0] first_base;
  logic          first_set;
  logic [OB-1:0] base_total;
  logic [OB-1:0] line_w;
  logic          mm_flag;
  logic          empty_flag;
  logic [31:0]   rec_count;
  logic          halted;

  logic [OB-1:0] byte_position_next;
  logic          at_line_start_next;
  logic [1:0]    line_class_next;
  logic [OB-1:0] cur_count_next;
  logic [OB-1:0] cur_start_next;
  logic          qskip_next;
  logic          header_seen_next;
  logic [OB-1:0] hdr_start_next;
  logic [OB-1:0] first_base_next;
  logic          first_set_next;
  logic [OB-1:0] base_total_next;
  logic [OB-1:0] line_w_next;
  logic          mm_flag_next;
  logic          empty_flag_next;
  logic [31:0]   rec_count_next;
  logic          halted_next;

  logic       step;
  logic       restart;
  logic       is_end;
  logic [1:0] new_cls;
  logic [1:0] cls_eff;
  logic       hdr_line;
  logic       hdr_emit;
  logic       err;
  logic       emit;
  logic [1:0] emit_kind;
  logic [OB-1:0] cnt_base;
  logic [OB-1:0] start_eff;
  logic [OB-1:0] width_new;

  // Fields of the record being emitted.
  logic [OB-1:0] src_hdr;
  logic [OB-1:0] src_fb;
  logic          src_fs;
  logic [OB-1:0] src_tot;
  logic [OB-1:0] src_lw;
  result_t       res_next;

  // A word leaves the queue whenever the output register can take a result.
  assign pop     = !q_stat.empty && (!res_valid || res_ready);
  assign step    = pop;
  assign restart = step && in_cls.eoi;

  // Work out the effect of one byte.
  always_comb begin
    is_end  = in_cls.is_nl || in_cls.eoi;
    if (qskip || in_cls.is_comment) new_cls = CLS_SKIP;
    else if (in_cls.is_plus)        new_cls = CLS_QUAL;
    else if (in_cls.is_header)      new_cls = CLS_HDR;
    else                            new_cls = CLS_SEQ;
    cls_eff   = at_line_start ? new_cls : line_class;
    hdr_line  = at_line_start && (new_cls == CLS_HDR);
    hdr_emit  = hdr_line && header_seen;
    cnt_base  = at_line_start ? '0 : cur_count;
    cur_count_next = in_cls.is_nl ? cnt_base : sat_inc(cnt_base);
    start_eff = at_line_start ? byte_position : cur_start;
    width_new = sat_inc(cur_count_next);

    byte_position_next = sat_inc(byte_position);
    at_line_start_next = is_end;
    line_class_next    = cls_eff;
    cur_start_next     = start_eff;
    qskip_next         = (at_line_start ? 1'b0 : qskip) || (is_end && cls_eff == CLS_QUAL);
    header_seen_next   = header_seen || hdr_line;
    hdr_start_next     = hdr_line ? byte_position : hdr_start;
    rec_count_next     = (hdr_emit && rec_count != '1) ? rec_count + 32'd1 : rec_count;

    // A new header closes the record and clears it.
    if (hdr_emit) begin
      first_base_next = '0;
      first_set_next  = 1'b0;
      base_total_next = '0;
      line_w_next     = '0;
      mm_flag_next    = 1'b0;
      empty_flag_next = 1'b0;
    end else begin
      first_base_next = first_base;
      first_set_next  = first_set;
      base_total_next = base_total;
      line_w_next     = line_w;
      mm_flag_next    = mm_flag;
      empty_flag_next = empty_flag;
    end

    // The end of a sequence line updates the record and checks its length.
    err = 1'b0;
    if (is_end && cls_eff == CLS_SEQ) begin
      if (!first_set_next) begin
        first_base_next = start_eff;
        first_set_next  = 1'b1;
      end
      base_total_next = sat_add(base_total_next, cur_count_next);
      if (line_w_next != '0) begin
        if (mm_flag_next || empty_flag_next) begin
          if (cur_count_next == '0) empty_flag_next = 1'b1;
          else                      err = 1'b1;
        end
        if (!err && line_w_next != width_new) begin
          mm_flag_next = 1'b1;
          if (cur_count_next == '0) empty_flag_next = 1'b1;
        end
      end else begin
        line_w_next = width_new;
      end
    end
    halted_next = err;

    // Pick the result, if any.
    src_hdr = hdr_start_next;
    src_fb  = first_base_next;
    src_fs  = first_set_next;
    src_tot = base_total_next;
    src_lw  = line_w_next;
    emit      = 1'b0;
    emit_kind = KIND_RECORD;
    if (hdr_emit) begin
      emit    = 1'b1;
      src_hdr = hdr_start;
      src_fb  = first_base;
      src_fs  = first_set;
      src_tot = base_total;
      src_lw  = line_w;
    end else if (err) begin
      emit      = 1'b1;
      emit_kind = empty_flag_next ? KIND_EMPTY : KIND_MISMATCH;
    end else if (in_cls.eoi && header_seen_next) begin
      emit = 1'b1;
    end
    emit = emit && !halted;

    res_next.kind            = emit_kind;
    res_next.record_number   = rec_count;
    res_next.header_offset   = OUT_W'(src_hdr);
    res_next.sequence_offset = src_fs ? OUT_W'(src_fb) : '0;
    res_next.has_sequence    = src_fs;
    res_next.sequence_length = OUT_W'(src_tot);
    res_next.line_bases      = (src_lw != '0) ? OUT_W'(src_lw - OB'(1)) : '0;
    res_next.line_width      = OUT_W'(src_lw);
  end

  // State registers; the end of input returns everything to its reset value.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      byte_position <= '0;
      at_line_start <= 1'b1;
      line_class    <= CLS_SEQ;
      cur_count     <= '0;
      cur_start     <= '0;
      qskip         <= 1'b0;
      header_seen   <= 1'b0;
      hdr_start     <= '0;
      first_base    <= '0;
      first_set     <= 1'b0;
      base_total    <= '0;
      line_w        <= '0;
      mm_flag       <= 1'b0;
      empty_flag    <= 1'b0;
      rec_count     <= '0;
      halted        <= 1'b0;
    end else if (step && !halted) begin
      byte_position <= byte_position_next;
      at_line_start <= at_line_start_next;
      line_class    <= line_class_next;
      cur_count     <= cur_count_next;
      cur_start     <= cur_start_next;
      qskip         <= qskip_next;
      header_seen   <= header_seen_next;
      hdr_start     <= hdr_start_next;
      first_base    <= first_base_next;
      first_set     <= first_set_next;
      base_total    <= base_total_next;
      line_w        <= line_w_next;
      mm_flag       <= mm_flag_next;
      empty_flag    <= empty_flag_next;
      rec_count     <= rec_count_next;
      halted        <= halted_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step && emit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) res <= res_next;
  end

endmodule

>>> sv/fasta_index_builder.sv
// Channel   Direction  Word contents
// s_axis    in         tdata[7:0] data_byte, tlast end_of_input
// m_axis    out        tdata record and line figures, tuser kind and sequence flag
//
// One byte is taken per cycle while the queue has room; a byte passes through a
// four-word classification queue and the back end before reaching the result register.
// The back end retires one queued byte per cycle while the result register is
// free or being read; a stalled result holds the back end, and the queue keeps
// the input side flowing until it fills.
// Reset is synchronous and active high and needs no clearing pass.
`include "fasta_index_builder_defines.svh"

module fasta_index_builder #(
  parameter int OFFSET_BITS = 40
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // [7:0] data_byte
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] record_number, [71:32] header_offset, [111:72] sequence_offset,
  // [151:112] sequence_length, [191:152] line_bases, [231:192] line_width
  output logic [231:0] m_axis_tdata,
  output logic [2:0]   m_axis_tuser   // [1:0] result_kind, [2] has_sequence
);
  import fib_pkg::*;

  byte_class_t front_cls;
  byte_class_t back_cls;
  q_status_t   q_stat;
  logic        push;
  logic        pop;
  result_t     res;

  // Front end: classify the incoming byte.
  fib_front u_front (
    .data_byte    (s_axis_tdata),
    .end_of_input (s_axis_tlast),
    .cls          (front_cls)
  );

  assign s_axis_tready = !q_stat.full;
  assign push          = s_axis_tvalid && s_axis_tready;

  // Queue between the two halves.
  fib_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (front_cls),
    .pop  (pop),
    .dout (back_cls),
    .stat (q_stat)
  );

  // Back end: record keeping and result register.
  fib_back #(
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_cls    (back_cls),
    .q_stat    (q_stat),
    .pop       (pop),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  // Pack the result word.
  assign m_axis_tdata = {res.line_width, res.line_bases, res.sequence_length,
                         res.sequence_offset, res.header_offset, res.record_number};
  assign m_axis_tuser = {res.has_sequence, res.kind};

  // The back end never retires a byte while a result is held back.
  `FIB_ASSERT_SAME(a_no_pop_on_stall, clk, rst, pop, !m_axis_tvalid || m_axis_tready)
  // Only the three defined kinds are ever produced.
  `FIB_ASSERT_SAME(a_kind_valid, clk, rst, m_axis_tvalid, res.kind != 2'd3)
  // An error result always belongs to a record that has sequence lines.
  `FIB_ASSERT_SAME(a_error_has_seq, clk, rst,
                   m_axis_tvalid && res.kind != KIND_RECORD, res.has_sequence)
  // Nothing is popped from an empty queue.
  `FIB_ASSERT_NEXT(a_pop_nonempty, clk, rst, q_stat.empty && !push, !pop || !q_stat.empty)

endmodule

>>> verif/fasta_index_builder_tb.sv
module fasta_index_builder_tb;
  import fib_pkg::*;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam int RANDOM_WORDS = 550;
  localparam int RANDOM_HEADERS = 40;
  localparam int SETTLE_CYCLES = 20;
  localparam int LONG_HOLD = 300;

  // One input word: a file byte and the end-of-file mark.
  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } in_word_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;   // [7:0] data_byte
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // [31:0] record_number, [71:32] header_offset, [111:72] sequence_offset,
  // [151:112] sequence_length, [191:152] line_bases, [231:192] line_width
  logic [231:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;        // [1:0] result_kind, [2] has_sequence

  fasta_index_builder u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Index state of the block as predicted from the accepted bytes.
  logic [OUT_W-1:0] file_pos;
  logic             at_start;
  logic [1:0]       line_cls;
  logic [OUT_W-1:0] line_bytes;
  logic [OUT_W-1:0] line_begin;
  logic             skip_quality;
  logic             in_record;
  logic [OUT_W-1:0] hdr_off;
  logic [OUT_W-1:0] first_base_off;
  logic             first_base_set;
  logic [OUT_W-1:0] base_total;
  logic [OUT_W-1:0] rec_width;
  logic             width_mismatch;
  logic             saw_empty;
  logic [31:0]      rec_no;
  logic             stopped;

  result_t  due_entries[$];
  in_word_t word_queue[$];
  logic [7:0] file_buf[$];

  int  words_queued = 0;
  int  words_taken = 0;
  int  headers_made = 0;
  int  entries_seen = 0;
  int  errors = 0;
  logic in_took = 1'b0;

  string base_chars = "ACGTNacgtR";

  function automatic logic [OUT_W-1:0] sat_add(logic [OUT_W-1:0] a, logic [OUT_W-1:0] b);
    logic [OUT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[OUT_W] ? '1 : sum[OUT_W-1:0];
  endfunction

  function automatic result_t index_entry(logic [1:0] kind);
    result_t e;
    e.kind            = kind;
    e.record_number   = rec_no;
    e.header_offset   = hdr_off;
    e.sequence_offset = first_base_set ? first_base_off : '0;
    e.has_sequence    = first_base_set;
    e.sequence_length = base_total;
    e.line_bases      = (rec_width != 0) ? rec_width - 1'b1 : '0;
    e.line_width      = rec_width;
    return e;
  endfunction

  function automatic string entry_text(result_t e);
    return $sformatf("kind %0d rec %0d hdr %0d seq %0d has %0d len %0d bases %0d width %0d",
                     e.kind, e.record_number, e.header_offset, e.sequence_offset,
                     e.has_sequence, e.sequence_length, e.line_bases, e.line_width);
  endfunction

  task automatic clear_record();
    first_base_off = '0;
    first_base_set = 1'b0;
    base_total     = '0;
    rec_width      = '0;
    width_mismatch = 1'b0;
    saw_empty      = 1'b0;
  endtask

  task automatic index_clear();
    file_pos     = '0;
    at_start     = 1'b1;
    line_cls     = CLS_SEQ;
    line_bytes   = '0;
    line_begin   = '0;
    skip_quality = 1'b0;
    in_record    = 1'b0;
    hdr_off      = '0;
    rec_no       = '0;
    stopped      = 1'b0;
    clear_record();
  endtask

  // Advance the index by one accepted byte and queue any entry it closes.
  task automatic index_step(logic [7:0] b, logic eoi);
    logic [OUT_W-1:0] w;
    logic             emitted;
    emitted = 1'b0;
    if (stopped) begin
      if (eoi) index_clear();
      return;
    end

    // The first byte of a line decides its class.
    if (at_start) begin
      at_start   = 1'b0;
      line_begin = file_pos;
      line_bytes = '0;
      if (skip_quality) begin
        skip_quality = 1'b0;
        line_cls     = CLS_SKIP;
      end else if (b == CH_SEMI) begin
        line_cls = CLS_SKIP;
      end else if (b == CH_PLUS) begin
        line_cls = CLS_QUAL;
      end else if (b == CH_GT || b == CH_AT) begin
        line_cls = CLS_HDR;
        if (in_record) begin
          due_entries.push_back(index_entry(KIND_RECORD));
          emitted = 1'b1;
          if (rec_no != '1) rec_no++;
          clear_record();
        end
        in_record = 1'b1;
        hdr_off   = line_begin;
      end else begin
        line_cls = CLS_SEQ;
      end
    end

    if (b != CH_NL) line_bytes = sat_add(line_bytes, OUT_W'(1));
    file_pos = sat_add(file_pos, OUT_W'(1));

    // A newline, or the last byte of the file, closes the line.
    if (b == CH_NL || eoi) begin
      at_start = 1'b1;
      if (line_cls == CLS_QUAL) begin
        skip_quality = 1'b1;
      end else if (line_cls == CLS_SEQ) begin
        w = sat_add(line_bytes, OUT_W'(1));
        if (!first_base_set) begin
          first_base_off = line_begin;
          first_base_set = 1'b1;
        end
        base_total = sat_add(base_total, line_bytes);
        if (rec_width != 0) begin
          // Once flagged, only empty lines may follow; anything else stops the block.
          if (width_mismatch || saw_empty) begin
            if (line_bytes == 0) begin
              saw_empty = 1'b1;
            end else begin
              due_entries.push_back(index_entry(saw_empty ? KIND_EMPTY : KIND_MISMATCH));
              stopped = 1'b1;
              if (eoi) index_clear();
              return;
            end
          end
          if (rec_width != w) begin
            width_mismatch = 1'b1;
            if (line_bytes == 0) saw_empty = 1'b1;
          end
        end else begin
          rec_width = w;
        end
      end
    end

    if (eoi) begin
      if (!emitted && in_record) due_entries.push_back(index_entry(KIND_RECORD));
      index_clear();
    end
  endtask

  // File building.
  task automatic add_byte(logic [7:0] b);
    file_buf.push_back(b);
  endtask

  task automatic add_text(string s, bit nl);
    for (int i = 0; i < s.len(); i++) file_buf.push_back(s[i]);
    if (nl) file_buf.push_back(CH_NL);
  endtask

  task automatic close_file();
    in_word_t w;
    for (int i = 0; i < file_buf.size(); i++) begin
      w.data = file_buf[i];
      w.last = (i == file_buf.size() - 1);
      word_queue.push_back(w);
      words_queued++;
    end
    file_buf.delete();
  endtask

  function automatic logic [7:0] rand_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 254));
    if (b >= CH_NL) b++;
    return b;
  endfunction

  function automatic logic [7:0] rand_base();
    if ($urandom_range(0, 99) < 85) return base_chars[$urandom_range(0, base_chars.len() - 1)];
    return rand_byte();
  endfunction

  // A run of n bytes closed by a newline; any selects arbitrary bytes over bases.
  task automatic add_run(int n, bit any);
    for (int i = 0; i < n; i++) file_buf.push_back(any ? rand_byte() : rand_base());
    file_buf.push_back(CH_NL);
  endtask

  // One record, mostly well formed, now and then with a bad or empty line.
  task automatic gen_record();
    int width;
    int nlines;
    int len;
    int r;
    bit fastq;
    fastq = ($urandom_range(0, 3) == 0);
    headers_made++;
    add_byte((fastq || $urandom_range(0, 5) == 0) ? CH_AT : CH_GT);
    add_run($urandom_range(0, 3), 1'b0);
    width  = $urandom_range(1, 5);
    nlines = fastq ? 1 : $urandom_range(0, 3);
    for (int i = 0; i < nlines; i++) begin
      len = (i == nlines - 1) ? $urandom_range(1, width) : width;
      r = $urandom_range(0, 99);
      if (r < 4) begin
        len = $urandom_range(1, width + 3);
      end else if (r < 7) begin
        len = 0;
      end else if (r < 10) begin
        add_byte(CH_SEMI);
        add_run($urandom_range(0, 3), 1'b1);
      end
      add_run(len, 1'b0);
    end
    if (fastq) begin
      add_byte(CH_PLUS);
      add_run($urandom_range(0, 2), 1'b0);
      add_run(width, 1'b1);
    end
    if ($urandom_range(0, 19) == 0) add_run(0, 1'b0);
  endtask

  task automatic gen_file();
    int nrec;
    // Sequence ahead of the first header, and a leading comment.
    if ($urandom_range(0, 9) == 0) add_run($urandom_range(0, 4), 1'b0);
    if ($urandom_range(0, 9) == 0) begin
      add_byte(CH_SEMI);
      add_run(2, 1'b1);
    end
    nrec = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
    for (int i = 0; i < nrec; i++) gen_record();
    if ($urandom_range(0, 9) == 0) add_run($urandom_range(1, 6), 1'b1);
    // Ending: a bare header as the last byte, no final newline, or a plain newline.
    case ($urandom_range(0, 9))
      0: add_byte(CH_GT);
      1, 2, 3: begin
        if (file_buf.size() > 1 && file_buf[$] == CH_NL) file_buf = file_buf[0:$-1];
      end
      default: ;
    endcase
    if (file_buf.size() == 0) add_byte(CH_NL);
    close_file();
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic drain();
    while (words_taken < words_queued || due_entries.size() != 0) @(posedge clk);
  endtask

  // Input side: note acceptance at the rising edge.
  always @(posedge clk) begin
    in_took <= !rst && s_axis_tvalid && s_axis_tready;
  end

  // Input side: predict the accepted word and offer the next one at the falling edge.
  int       idle_left = 0;
  int       words_sent = 0;
  bit       in_burst = 1'b0;
  in_word_t next_word;
  always @(negedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (in_took) begin
        index_step(s_axis_tdata, s_axis_tlast);
        words_taken++;
      end
      if (!s_axis_tvalid || in_took) begin
        if (idle_left > 0) begin
          idle_left--;
          s_axis_tvalid <= 1'b0;
        end else if (word_queue.size() > 0) begin
          next_word = word_queue.pop_front();
          s_axis_tdata  <= next_word.data;
          s_axis_tlast  <= next_word.last;
          s_axis_tvalid <= 1'b1;
          words_sent++;
          if (words_sent % 48 == 0) in_burst = ($urandom_range(0, 3) == 0);
          idle_left = in_burst ? 0 : pick_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output side: random stalls, quiet stretches and one long hold.
  int rx_cycles = 0;
  int hold_left = 0;
  int rx_roll;
  bit rx_burst = 1'b0;
  bit long_hold_done = 1'b0;
  always @(negedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_cycles++;
      if (rx_cycles % 64 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      if (!long_hold_done && entries_seen >= 6) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (rx_burst) begin
        m_axis_tready <= 1'b1;
      end else begin
        rx_roll = $urandom_range(0, 99);
        if (rx_roll < 65) begin
          m_axis_tready <= 1'b1;
        end else begin
          m_axis_tready <= 1'b0;
          hold_left = (rx_roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
        end
      end
    end
  end

  // Output side: compare each accepted word with the oldest predicted entry.
  result_t seen_entry;
  result_t want_entry;
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen_entry.kind            = m_axis_tuser[1:0];
      seen_entry.has_sequence    = m_axis_tuser[2];
      seen_entry.record_number   = m_axis_tdata[31:0];
      seen_entry.header_offset   = m_axis_tdata[71:32];
      seen_entry.sequence_offset = m_axis_tdata[111:72];
      seen_entry.sequence_length = m_axis_tdata[151:112];
      seen_entry.line_bases      = m_axis_tdata[191:152];
      seen_entry.line_width      = m_axis_tdata[231:192];
      entries_seen++;
      if (due_entries.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected entry: %s", entry_text(seen_entry));
      end else begin
        want_entry = due_entries.pop_front();
        if (seen_entry !== want_entry) begin
          errors++;
          if (errors <= 10)
            $display("entry mismatch\n  expected %s\n  actual   %s",
                     entry_text(want_entry), entry_text(seen_entry));
        end
      end
    end
  end

  initial begin
    #3200000;
    $display("DONE: errors detected");
    $finish;
  end

  bit paused = 1'b0;
  initial begin
    index_clear();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Mismatched line then a further base line: error entry, then a byte ignored
    // while stopped that also ends the file.
    add_byte(CH_GT);
    add_byte(CH_NL);
    add_text("AC", 1'b1);
    add_text("A", 1'b1);
    add_text("A", 1'b1);
    add_text("Z", 1'b0);
    close_file();
    // Carriage return as a base ahead of any header, a quality pair, a comment,
    // extreme byte values, an empty line, and a header as the very last byte.
    add_byte(CH_CR);
    add_byte(CH_NL);
    add_byte(CH_AT);
    add_byte(CH_NL);
    add_byte(CH_PLUS);
    add_byte(CH_NL);
    add_byte(8'hFF);
    add_byte(CH_NL);
    add_byte(CH_SEMI);
    add_byte(CH_NL);
    add_byte(8'h00);
    add_byte(CH_NL);
    add_byte(CH_NL);
    add_byte(CH_GT);
    close_file();

    // Random files; halfway through the sender waits for every entry to arrive.
    while (words_queued < RANDOM_WORDS || headers_made < RANDOM_HEADERS) begin
      gen_file();
      if (!paused && words_queued >= RANDOM_WORDS / 2) begin
        paused = 1'b1;
        drain();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+sv
sv/fib_pkg.sv
sv/fib_front.sv
sv/fib_queue.sv
sv/fib_back.sv
sv/fasta_index_builder.sv
verif/fasta_index_builder_tb.sv
